// File: rtl/shm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// shm_pkg
// Shared types and constants for the stepper homing and measuring block.
// ---------------------------------------------------------------------------
package shm_pkg;

    // width of the reverse pass counter (4 to 32)
    localparam int COUNT_WIDTH = 16;

    // fixed widths of the port fields
    localparam int HOLD_WIDTH  = 16;
    localparam int REV_WIDTH   = 16;
    localparam int COIL_WIDTH  = 4;

    // last half-step index of one pass
    localparam logic [2:0] LAST_HALF_STEP = 3'd7;

    // coil patterns at the first half-step pair of each direction
    localparam logic [COIL_WIDTH-1:0] COIL_FIRST_FWD = 4'b0001;
    localparam logic [COIL_WIDTH-1:0] COIL_FIRST_REV = 4'b1000;

    // start switch level that keeps the forward seek going
    localparam logic SEEK_ON_LEVEL = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEEK = 2'd1,
        MODE_MEAS = 2'd2,
        MODE_DONE = 2'd3
    } mode_t;

    // one input word
    typedef struct packed {
        logic start_cmd;
        logic start_level;
        logic end_level;
        logic abort_evt;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic [COIL_WIDTH-1:0] coils;
        logic                  busy_res;
        logic                  done_res;
        logic                  aborted;
        logic [REV_WIDTH-1:0]  rev_count;
    } out_word_t;

    // controller state carried from tick to tick
    typedef struct packed {
        mode_t                  mode;
        logic                   in_pass;
        logic [2:0]             half_step;
        logic [HOLD_WIDTH-1:0]  hold_count;
        logic [COUNT_WIDTH-1:0] pass_count;
        logic                   abort_latch;
    } ctrl_state_t;

endpackage : shm_pkg
`default_nettype wire

// File: rtl/stepper_home_and_measure.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stepper_home_and_measure
// Stepper homing seek and reverse travel measurement, one word per tick.
// ---------------------------------------------------------------------------
// Each input word is one timer tick and gives exactly one result word. The
// block takes one word per clock cycle, sustained, while the result side keeps
// up; each word passes through the input register, then the step logic into
// the result register. The rate is set by the state loop of the step logic,
// which updates mode, half-step, hold count and pass count from one word at a
// time. The user writes hold_ticks on the cfg port only while the block is
// idle, which the block itself does not enforce; it resets to 1 and a value of
// 0 behaves as 1. There is no memory and no clearing pass after reset.
// ---------------------------------------------------------------------------
module stepper_home_and_measure
    import shm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // tick words
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   start_cmd,
    input  wire logic                   start_level,
    input  wire logic                   end_level,
    input  wire logic                   abort_evt,
    // result words
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [COIL_WIDTH-1:0]       coils,
    output logic                        busy_res,
    output logic                        done_res,
    output logic                        aborted,
    output logic [REV_WIDTH-1:0]        rev_count,
    // configuration write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [HOLD_WIDTH-1:0]  cfg_data
);

    in_word_t              in_word;
    in_word_t              stage_word;
    logic                  stage_valid;
    logic                  step_en;
    logic                  out_free;
    logic                  in_load;
    ctrl_state_t           state_reg;
    ctrl_state_t           state_next;
    out_word_t             step_result;
    out_word_t             res_word;
    logic [HOLD_WIDTH-1:0] hold_ticks_reg;

    // handshake and stage advance
    assign out_free  = !out_valid || out_ready;
    assign step_en   = stage_valid && out_free;
    assign in_ready  = !stage_valid || out_free;
    assign in_load   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign in_word.start_cmd   = start_cmd;
    assign in_word.start_level = start_level;
    assign in_word.end_level   = end_level;
    assign in_word.abort_evt   = abort_evt;

    shm_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (in_load),
        .drain_en   (step_en),
        .word_in    (in_word),
        .word_valid (stage_valid),
        .word_out   (stage_word)
    );

    shm_step u_step (
        .word       (stage_word),
        .state_cur  (state_reg),
        .hold_ticks (hold_ticks_reg),
        .state_nxt  (state_next),
        .result     (step_result)
    );

    // controller state and hold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= MODE_IDLE;
            state_reg.in_pass     <= 1'b0;
            state_reg.half_step   <= '0;
            state_reg.hold_count  <= '0;
            state_reg.pass_count  <= '0;
            state_reg.abort_latch <= 1'b0;
            hold_ticks_reg        <= HOLD_WIDTH'(1);
        end
        else
        begin
            if (step_en)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                hold_ticks_reg <= cfg_data;
            end
        end
    end

    shm_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (step_en),
        .take_en    (out_ready),
        .word_in    (step_result),
        .word_valid (out_valid),
        .word_out   (res_word)
    );

    assign coils     = res_word.coils;
    assign busy_res  = res_word.busy_res;
    assign done_res  = res_word.done_res;
    assign aborted   = res_word.aborted;
    assign rev_count = res_word.rev_count;

    // checks on the controller
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.in_pass |-> (state_reg.hold_count == '0 && state_reg.half_step == '0))
        else $error("hold count or half-step left over outside a pass");

    a_pass_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.in_pass |-> (state_reg.mode == MODE_SEEK || state_reg.mode == MODE_MEAS))
        else $error("pass running while not seeking or measuring");

    a_coils_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($onehot0(coils) && (coils == '0 || busy_res)))
        else $error("coil pattern not one-hot or driven while not busy");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(busy_res && done_res) && (!aborted || done_res)))
        else $error("inconsistent busy, done and aborted flags");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && state_reg.mode == MODE_SEEK) |=>
            (state_reg.pass_count == $past(state_reg.pass_count)))
        else $error("pass count changed during the forward seek");

endmodule : stepper_home_and_measure
`default_nettype wire

// File: rtl/shm_in_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// shm_in_reg
// Input register stage: holds one accepted tick word for the step logic.
// ---------------------------------------------------------------------------
module shm_in_reg
    import shm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load_en,
    input  wire logic     drain_en,
    input  wire in_word_t word_in,
    output logic          word_valid,
    output in_word_t      word_out
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // valid flag: set on load, cleared when drained without refill
    always_comb
    begin
        valid_next = valid_reg;
        if (load_en)
        begin
            valid_next = 1'b1;
        end
        else if (drain_en)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            word_reg <= word_in;
        end
    end

    assign word_valid = valid_reg;
    assign word_out   = word_reg;

endmodule : shm_in_reg
`default_nettype wire

// File: rtl/shm_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// shm_step
// One tick of the homing controller: start, abort latch, boundary decision
// and half-step drive, giving the next state and the result word.
// ---------------------------------------------------------------------------
module shm_step
    import shm_pkg::*;
(
    input  wire in_word_t              word,
    input  wire ctrl_state_t           state_cur,
    input  wire logic [HOLD_WIDTH-1:0] hold_ticks,
    output ctrl_state_t                state_nxt,
    output out_word_t                  result
);

    ctrl_state_t             s0;
    ctrl_state_t             s1;
    ctrl_state_t             s2;
    ctrl_state_t             s3;
    logic [HOLD_WIDTH-1:0]   hold_eff;
    logic [HOLD_WIDTH-1:0]   hold_inc;
    logic [COIL_WIDTH-1:0]   coil_pat;
    logic [1:0]              coil_idx;
    logic [COUNT_WIDTH+REV_WIDTH-1:0] count_ext;

    // a zero hold behaves as one tick
    assign hold_eff = (hold_ticks == '0) ? HOLD_WIDTH'(1) : hold_ticks;

    // start command and abort latch
    always_comb
    begin
        s0 = state_cur;
        if (word.start_cmd && (s0.mode == MODE_IDLE || s0.mode == MODE_DONE))
        begin
            s0.mode        = MODE_SEEK;
            s0.in_pass     = 1'b0;
            s0.half_step   = '0;
            s0.hold_count  = '0;
            s0.pass_count  = '0;
            s0.abort_latch = 1'b0;
        end
        if (s0.mode == MODE_SEEK || s0.mode == MODE_MEAS)
        begin
            s0.abort_latch = s0.abort_latch | word.abort_evt;
        end
    end

    // pass boundary: forward seek first, then reverse measure in the same tick
    always_comb
    begin
        s1 = s0;
        if (!s1.in_pass && s1.mode == MODE_SEEK)
        begin
            if (word.start_level == SEEK_ON_LEVEL && !s1.abort_latch)
            begin
                s1.in_pass    = 1'b1;
                s1.half_step  = '0;
                s1.hold_count = '0;
            end
            else
            begin
                s1.mode = MODE_MEAS;
            end
        end
        s2 = s1;
        if (!s2.in_pass && s2.mode == MODE_MEAS)
        begin
            if (word.end_level && !s2.abort_latch)
            begin
                s2.in_pass    = 1'b1;
                s2.half_step  = '0;
                s2.hold_count = '0;
            end
            else
            begin
                s2.mode = MODE_DONE;
            end
        end
    end

    // half-step drive and pass counting
    assign coil_idx = s2.half_step[2:1];
    assign hold_inc = s2.hold_count + HOLD_WIDTH'(1);

    always_comb
    begin
        s3       = s2;
        coil_pat = '0;
        if (s2.in_pass)
        begin
            coil_pat      = (s2.mode == MODE_SEEK) ? (COIL_FIRST_FWD << coil_idx)
                                                   : (COIL_FIRST_REV >> coil_idx);
            s3.hold_count = hold_inc;
            if (hold_inc >= hold_eff)
            begin
                s3.hold_count = '0;
                if (s2.half_step == LAST_HALF_STEP)
                begin
                    s3.half_step = '0;
                    s3.in_pass   = 1'b0;
                    if (s2.mode == MODE_MEAS && s2.pass_count != '1)
                    begin
                        s3.pass_count = s2.pass_count + COUNT_WIDTH'(1);
                    end
                end
                else
                begin
                    s3.half_step = s2.half_step + 3'd1;
                end
            end
        end
    end

    // result word
    assign count_ext = {{REV_WIDTH{1'b0}}, s3.pass_count};

    always_comb
    begin
        result.coils     = coil_pat;
        result.busy_res  = (s3.mode == MODE_SEEK || s3.mode == MODE_MEAS);
        result.done_res  = (s3.mode == MODE_DONE);
        result.aborted   = (s3.mode == MODE_DONE) && s3.abort_latch;
        result.rev_count = count_ext[REV_WIDTH-1:0];
    end

    assign state_nxt = s3;

endmodule : shm_step
`default_nettype wire

// File: rtl/shm_out_reg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// shm_out_reg
// Result register: holds one result word until the consumer takes it.
// ---------------------------------------------------------------------------
module shm_out_reg
    import shm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load_en,
    input  wire logic      take_en,
    input  wire out_word_t word_in,
    output logic           word_valid,
    output out_word_t      word_out
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // valid flag: load wins over a take in the same cycle
    always_comb
    begin
        valid_next = valid_reg;
        if (load_en)
        begin
            valid_next = 1'b1;
        end
        else if (take_en)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            word_reg <= word_in;
        end
    end

    assign word_valid = valid_reg;
    assign word_out   = word_reg;

endmodule : shm_out_reg
`default_nettype wire

// File: tb/sv/stepper_drive_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stepper_drive_checker
// Follows the tick, result and hold-setting channels of the homing block,
// works out the coil drive and status for every accepted tick word and
// compares each result word with the oldest one still owed.
// ---------------------------------------------------------------------------
module stepper_drive_checker
    import shm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // tick words
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic                  start_cmd,
    input  wire logic                  start_level,
    input  wire logic                  end_level,
    input  wire logic                  abort_evt,
    // result words
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [COIL_WIDTH-1:0] coils,
    input  wire logic                  busy_res,
    input  wire logic                  done_res,
    input  wire logic                  aborted,
    input  wire logic [REV_WIDTH-1:0]  rev_count,
    // hold setting writes
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [HOLD_WIDTH-1:0] cfg_data,
    // tallies for the test top
    output int                         fail_count,
    output int                         pending,
    output int                         checked,
    output int                         finishes,
    output int                         abort_finishes,
    output int                         peak_count
);

    // only the first few mismatches are printed, all are counted
    localparam int REPORT_LIMIT = 30;

    // own copy of the controller state
    mode_t                  seq_mode;
    logic                   pass_active;
    logic [2:0]             half_idx;
    logic [HOLD_WIDTH-1:0]  dwell_count;
    logic [COUNT_WIDTH-1:0] rev_passes;
    logic                   abort_seen;
    logic [HOLD_WIDTH-1:0]  hold_setting;

    // drive words owed by the block, oldest first
    out_word_t              owed_drive[$];

    // one tick of the homing controller
    task automatic advance_homing(input in_word_t tick, output out_word_t drive);
        logic [HOLD_WIDTH-1:0] hold_eff;
        logic [1:0]            coil_idx;
        hold_eff = (hold_setting == '0) ? HOLD_WIDTH'(1) : hold_setting;
        drive = '0;

        // a start from idle or done clears everything and begins the seek
        if (tick.start_cmd && (seq_mode == MODE_IDLE || seq_mode == MODE_DONE))
        begin
            seq_mode    = MODE_SEEK;
            pass_active = 1'b0;
            half_idx    = '0;
            dwell_count = '0;
            rev_passes  = '0;
            abort_seen  = 1'b0;
        end

        if (seq_mode == MODE_SEEK || seq_mode == MODE_MEAS)
            abort_seen = abort_seen | tick.abort_evt;

        // pass boundary: carry on forward or turn to measuring, then reverse or finish
        if (!pass_active && seq_mode == MODE_SEEK)
        begin
            if (tick.start_level == SEEK_ON_LEVEL && !abort_seen)
            begin
                pass_active = 1'b1;
                half_idx    = '0;
                dwell_count = '0;
            end
            else
                seq_mode = MODE_MEAS;
        end
        if (!pass_active && seq_mode == MODE_MEAS)
        begin
            if (tick.end_level == 1'b1 && !abort_seen)
            begin
                pass_active = 1'b1;
                half_idx    = '0;
                dwell_count = '0;
            end
            else
            begin
                seq_mode = MODE_DONE;
                finishes++;
                if (abort_seen)
                    abort_finishes++;
            end
        end

        // drive one coil and step through the half-steps
        if (pass_active)
        begin
            coil_idx = half_idx[2:1];
            drive.coils = (seq_mode == MODE_SEEK) ? (COIL_FIRST_FWD << coil_idx)
                                                  : (COIL_FIRST_REV >> coil_idx);
            dwell_count = dwell_count + 1'b1;
            if (dwell_count >= hold_eff)
            begin
                dwell_count = '0;
                if (half_idx >= LAST_HALF_STEP)
                begin
                    half_idx    = '0;
                    pass_active = 1'b0;
                    if (seq_mode == MODE_MEAS && rev_passes != '1)
                        rev_passes = rev_passes + 1'b1;
                end
                else
                    half_idx = half_idx + 1'b1;
            end
        end

        drive.busy_res  = (seq_mode == MODE_SEEK || seq_mode == MODE_MEAS);
        drive.done_res  = (seq_mode == MODE_DONE);
        drive.aborted   = (seq_mode == MODE_DONE) && abort_seen;
        drive.rev_count = REV_WIDTH'(rev_passes);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        in_word_t  tick;
        if (!rst_n)
        begin
            seq_mode       = MODE_IDLE;
            pass_active    = 1'b0;
            half_idx       = '0;
            dwell_count    = '0;
            rev_passes     = '0;
            abort_seen     = 1'b0;
            hold_setting   = HOLD_WIDTH'(1);
            owed_drive.delete();
            fail_count     = 0;
            pending        = 0;
            checked        = 0;
            finishes       = 0;
            abort_finishes = 0;
            peak_count     = 0;
        end
        else
        begin
            // result word against the oldest owed one
            if (out_valid && out_ready)
            begin
                if (owed_drive.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%t: result word with nothing owed, expected none, %s",
                                 $time, "got a result word");
                    if (fail_count <= REPORT_LIMIT)
                        $display("    coils %0d busy %0d done %0d aborted %0d count %0d",
                                 coils, busy_res, done_res, aborted, rev_count);
                end
                else
                begin
                    want = owed_drive.pop_front();
                    compare_field("coils", 32'(want.coils), 32'(coils));
                    compare_field("busy_res", 32'(want.busy_res), 32'(busy_res));
                    compare_field("done_res", 32'(want.done_res), 32'(done_res));
                    compare_field("aborted", 32'(want.aborted), 32'(aborted));
                    compare_field("rev_count", 32'(want.rev_count), 32'(rev_count));
                    checked++;
                end
            end

            if (cfg_valid && cfg_ready)
                hold_setting = cfg_data;

            if (in_valid && in_ready)
            begin
                tick.start_cmd   = start_cmd;
                tick.start_level = start_level;
                tick.end_level   = end_level;
                tick.abort_evt   = abort_evt;
                advance_homing(tick, want);
                if (int'(want.rev_count) > peak_count)
                    peak_count = int'(want.rev_count);
                owed_drive.push_back(want);
            end

            pending = owed_drive.size();
        end
    end

endmodule

// File: tb/sv/stepper_home_and_measure_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stepper_home_and_measure_test
// Feeds tick words, hold settings and random result back-pressure into the
// homing block: a short opening sequence and randomised homing runs over
// several hold settings. The checker beside the block predicts and compares
// every result.
// ---------------------------------------------------------------------------
module stepper_home_and_measure_test;
    import shm_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_WORDS = 1250;
    localparam int LONG_HOLD    = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  start_cmd   = 1'b0;
    logic                  start_level = 1'b0;
    logic                  end_level   = 1'b0;
    logic                  abort_evt   = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [COIL_WIDTH-1:0] coils;
    logic                  busy_res;
    logic                  done_res;
    logic                  aborted;
    logic [REV_WIDTH-1:0]  rev_count;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [HOLD_WIDTH-1:0] cfg_data    = '0;

    int fail_count;
    int pending;
    int checked;
    int finishes;
    int abort_finishes;
    int peak_count;

    // pacing shared by the sender and the result sink
    int tx_max_gap       = 15;
    int rx_max_stall     = 15;
    bit long_hold_req    = 1'b0;
    int cur_hold         = 1;
    int words_sent       = 0;
    int settings_written = 0;
    int quiet_cycles     = 0;

    logic [3:0] opening_ticks [24];

    always #(CLK_PERIOD / 2) clk = ~clk;

    stepper_home_and_measure u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_cmd   (start_cmd),
        .start_level (start_level),
        .end_level   (end_level),
        .abort_evt   (abort_evt),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coils       (coils),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .aborted     (aborted),
        .rev_count   (rev_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    stepper_drive_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_cmd      (start_cmd),
        .start_level    (start_level),
        .end_level      (end_level),
        .abort_evt      (abort_evt),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .coils          (coils),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .aborted        (aborted),
        .rev_count      (rev_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .finishes       (finishes),
        .abort_finishes (abort_finishes),
        .peak_count     (peak_count)
    );

    // one tick word, after a random gap, held until taken
    task automatic send_tick(input in_word_t w);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        start_cmd   <= w.start_cmd;
        start_level <= w.start_level;
        end_level   <= w.end_level;
        abort_evt   <= w.abort_evt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // new hold setting, only once every owed result has come back
    task automatic write_hold(input logic [HOLD_WIDTH-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_hold = int'(value);
        settings_written++;
    endtask

    // start, some forward seeking, some measuring, then let it finish
    task automatic homing_run();
        int       hold_eff;
        int       pass_len;
        int       fwd;
        int       rev;
        int       tail;
        bit       aborts_on;
        in_word_t w;
        hold_eff  = (cur_hold == 0) ? 1 : cur_hold;
        pass_len  = 8 * hold_eff;
        fwd       = $urandom_range(0, 2 * pass_len);
        rev       = $urandom_range(0, 3 * pass_len);
        tail      = pass_len + $urandom_range(1, 4);
        aborts_on = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 1 + fwd + rev + tail; i++)
        begin
            w.start_cmd   = (i == 0) || ($urandom_range(0, 15) == 0);
            w.start_level = (i < 1 + fwd);
            w.end_level   = (i < 1 + fwd) ? 1'($urandom_range(0, 1)) : (i < 1 + fwd + rev);
            w.abort_evt   = aborts_on && ($urandom_range(0, 47) == 0);
            send_tick(w);
        end
    endtask

    // result sink: random stall per word, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, rx_max_stall);
            if (long_hold_req)
            begin
                stall = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    // watchdog on cycles in which no word moves on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%t: watchdog, no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        in_word_t              w;
        int                    target;
        logic [HOLD_WIDTH-1:0] hold_plan [6];

        // idle, ignored abort, forward pass with a start while busy, turn to
        // measuring on the boundary tick, one reverse pass, done; abort while
        // done, start together with abort, restart from done, abort mid-pass
        opening_ticks = '{4'b0000, 4'b0001, 4'b1100, 4'b0100, 4'b1100, 4'b0100,
                          4'b0110, 4'b0100, 4'b0100, 4'b0100, 4'b0010, 4'b0010,
                          4'b0010, 4'b0110, 4'b0010, 4'b0010, 4'b0010, 4'b0010,
                          4'b0000, 4'b0001, 4'b1101, 4'b1000, 4'b1110, 4'b0101};
        hold_plan = '{16'd2, 16'd0, 16'd5, 16'hFFFF, 16'd1, 16'd3};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // opening sequence on the reset hold value
        foreach (opening_ticks[i])
            send_tick(opening_ticks[i]);

        // random homing runs over several hold settings
        for (int p = 0; p < 6; p++)
        begin
            write_hold(hold_plan[p]);
            if (hold_plan[p] == 16'hFFFF)
            begin
                // longest hold: the seek never leaves its first half-step
                send_tick(4'b1100);
                repeat (40)
                begin
                    w = 4'($urandom_range(0, 15));
                    send_tick(w);
                end
            end
            else
            begin
                target = words_sent + RANDOM_WORDS / 5;
                if (p == 2)
                begin
                    // results held back while words keep coming
                    long_hold_req = 1'b1;
                    tx_max_gap    = 0;
                    homing_run();
                end
                while (words_sent < target)
                begin
                    tx_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 15;
                    rx_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 15;
                    if ($urandom_range(0, 6) == 0)
                    begin
                        repeat ($urandom_range(1, 12))
                        begin
                            w = 4'($urandom_range(0, 15));
                            send_tick(w);
                        end
                    end
                    else
                        homing_run();
                end
            end
        end

        // drain and settle
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d tick words, %0d results checked, %0d hold settings",
                 words_sent, checked, settings_written);
        $display("%0d measurements finished, %0d on abort, highest pass count %0d",
                 finishes, abort_finishes, peak_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
